[hdl/prs_pkg.sv]
package prs_pkg;

    localparam int ENTRIES     = 8;
    localparam int CHANNELS    = 2;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EP_W  = $clog2(CHANNELS + 1);
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int NO_W  = 8;
    localparam int ID_W  = 16;
    localparam int PER_W = 24;
    localparam int BC_W  = 8;
    localparam int CFG_IDX_W = 1;

    // item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_CMD  = 2'd1;
    localparam logic [1:0] MODE_ADD  = 2'd2;
    localparam logic [1:0] MODE_DEL  = 2'd3;

    // commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_ENABLE  = 3'd1;
    localparam logic [2:0] CMD_DISABLE = 3'd2;
    localparam logic [2:0] CMD_REFRESH = 3'd3;
    localparam logic [2:0] CMD_BURST   = 3'd4;

    // run modes
    localparam logic [1:0] RUN_IDLE    = 2'd0;
    localparam logic [1:0] RUN_REGULAR = 2'd1;
    localparam logic [1:0] RUN_BURST   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_COUNT  = 1'b1;

    typedef struct packed {
        logic [NO_W-1:0]  no;
        logic [ID_W-1:0]  cluster;
        logic [ID_W-1:0]  attr;
        logic             mfg;
        logic             one_ep;
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] countdown;
    } slot_t;

    typedef struct packed {
        logic             fill;
        logic             clear;
        logic             cd_we;
        logic [PER_W-1:0] cd;
    } slot_wr_t;

    typedef struct packed {
        logic decrement;
        logic burst;
    } walk_ctl_t;

    typedef struct packed {
        logic [1:0]      endpoint;
        logic [ID_W-1:0] cluster;
        logic [ID_W-1:0] attr;
        logic            mfg;
    } report_t;

endpackage

[hdl/prs_if.sv]
interface prs_item_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [2:0]                command;
    logic [prs_pkg::NO_W-1:0]  entry_no;
    logic [prs_pkg::ID_W-1:0]  cluster_id;
    logic [prs_pkg::ID_W-1:0]  attribute_id;
    logic                      is_mfg;
    logic [prs_pkg::PER_W-1:0] period;
    logic                      one_endpoint;

    modport source (output valid, mode, command, entry_no, cluster_id, attribute_id,
                    is_mfg, period, one_endpoint, input ready);
    modport sink   (input valid, mode, command, entry_no, cluster_id, attribute_id,
                    is_mfg, period, one_endpoint, output ready);
endinterface

interface prs_report_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               endpoint;
    logic [prs_pkg::ID_W-1:0] report_cluster;
    logic [prs_pkg::ID_W-1:0] report_attribute;
    logic                     report_mfg;
    logic                     last;

    modport source (output valid, endpoint, report_cluster, report_attribute, report_mfg,
                    last, input ready);
    modport sink   (input valid, endpoint, report_cluster, report_attribute, report_mfg,
                    last, output ready);
endinterface

interface prs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [prs_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/prs_slot_store.sv]
module prs_slot_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [prs_pkg::IDX_W-1:0]  idx,
    input  prs_pkg::slot_wr_t          wr,
    input  prs_pkg::slot_t             fill_data,
    output prs_pkg::slot_t             rd_data,
    output logic                       rd_valid
);
    import prs_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    slot_t              slot_reg [ENTRIES];

    assign rd_data  = slot_reg[idx];
    assign rd_valid = valid_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.fill)
        begin
            valid_reg[idx] <= 1'b1;
        end
        else if (wr.clear)
        begin
            valid_reg[idx] <= 1'b0;
        end
    end

    // slot contents are read only while valid
    always_ff @(posedge clk)
    begin
        if (wr.fill)
        begin
            slot_reg[idx] <= fill_data;
        end
        else if (wr.cd_we)
        begin
            slot_reg[idx].countdown <= wr.cd;
        end
    end

endmodule

[hdl/prs_count_unit.sv]
module prs_count_unit (
    input  prs_pkg::slot_t              slot,
    input  logic                        refresh_hit,
    input  prs_pkg::walk_ctl_t          ctl,
    output logic [prs_pkg::PER_W-1:0]   cd_next,
    output logic                        fire
);
    import prs_pkg::*;

    logic [PER_W-1:0] cd_eff;

    // refresh reloads before the decrement step
    assign cd_eff = refresh_hit ? slot.period : slot.countdown;

    always_comb
    begin
        fire    = 1'b0;
        cd_next = cd_eff;
        if (ctl.decrement)
        begin
            fire    = (cd_eff <= PER_W'(1));
            cd_next = fire ? slot.period : cd_eff - PER_W'(1);
        end
        else if (ctl.burst)
        begin
            fire    = 1'b1;
            cd_next = slot.period;
        end
    end

endmodule

[hdl/periodic_report_scheduler_unit.sv]
// Periodic report scheduler.
// item channel: one beat per operation. mode selects tick, command, add entry or
//   delete entry. A command beat needs no walk. Add and delete walk the slot
//   table one slot at a time after the accept; delete covers every slot.
// report channel: reports caused by a tick, in slot order, one beat each, with
//   last set on the final report of that tick. A tick returns no beat at all
//   when nothing falls due.
// cfg channel: writes short_period (index 0) and short_count (index 1); always
//   ready, taken in any cycle.
// Tick steps: the accept, then each slot in turn through the shared countdown
//   unit, a further step for each further endpoint of a slot that reports,
//   and a flush step that releases the final report. The single slot read
//   port and countdown unit set this one-slot-at-a-time walk.
// One report is held back so that last can be set once the walk ends; it moves to
//   the output register when the next report is found or at the flush.
// item.ready is high only between operations. A stalled receiver holds the
//   output register, and the walk waits at the next report it finds.
// Reset clears run mode, pending command, burst counters, slot valid bits and
//   output valid; configuration returns to 10 and 3.
module periodic_report_scheduler_unit (
    input  logic           clk,
    input  logic           rst_n,
    prs_item_if.sink       item,
    prs_report_if.source   report,
    prs_cfg_if.sink        cfg
);
    import prs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // sequencer
    logic [1:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [EP_W-1:0]  ep_reg, ep_next;
    logic             ref_active_reg, ref_active_next;
    walk_ctl_t        ctl_reg, ctl_next;
    logic [NO_W-1:0]  key_reg, key_next;
    slot_t            add_reg, add_next;
    logic [CNT_W-1:0] nrep_reg, nrep_next;

    // scheduler state
    logic [1:0]       run_mode_reg, run_mode_next;
    logic [2:0]       pend_cmd_reg, pend_cmd_next;
    logic [NO_W-1:0]  pend_entry_reg, pend_entry_next;
    logic [BC_W-1:0]  btick_reg, btick_next;
    logic [BC_W-1:0]  bcount_reg, bcount_next;
    logic [7:0]       sp_reg, sp_next;
    logic [7:0]       sc_reg, sc_next;

    // held report and output register
    logic             hold_valid_reg, hold_valid_next;
    report_t          hold_reg, hold_next;
    logic             out_valid_reg, out_valid_next;
    report_t          out_reg, out_next;
    logic             out_last_reg, out_last_next;

    // slot table and countdown unit
    slot_wr_t         wr;
    slot_t            rd_data;
    logic             rd_valid;
    logic             refresh_hit;
    logic [PER_W-1:0] cd_next;
    logic             fire;

    logic             item_fire;
    logic             out_free;
    logic             last_idx;
    logic             fresh;
    logic             key_match;

    prs_slot_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .idx       (idx_reg),
        .wr        (wr),
        .fill_data (add_reg),
        .rd_data   (rd_data),
        .rd_valid  (rd_valid)
    );

    prs_count_unit u_count (
        .slot        (rd_data),
        .refresh_hit (refresh_hit),
        .ctl         (ctl_reg),
        .cd_next     (cd_next),
        .fire        (fire)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign report.valid            = out_valid_reg;
    assign report.endpoint         = out_reg.endpoint;
    assign report.report_cluster   = out_reg.cluster;
    assign report.report_attribute = out_reg.attr;
    assign report.report_mfg       = out_reg.mfg;
    assign report.last             = out_last_reg;

    assign out_free    = !out_valid_reg || report.ready;
    assign last_idx    = (idx_reg == IDX_W'(ENTRIES - 1));
    assign fresh       = (ep_reg == '0);
    assign key_match   = rd_valid && (rd_data.no == key_reg);
    // only the lowest matching slot takes the refresh
    assign refresh_hit = ref_active_reg && fresh && key_match;

    always_comb
    begin
        logic [2:0]      cmd_in;
        logic [BC_W-1:0] bt_inc;
        logic [BC_W-1:0] bc_inc;
        logic            gen;
        logic            gen_ok;
        logic            stall;
        logic            more;
        report_t         rep;

        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        ep_next         = ep_reg;
        ref_active_next = ref_active_reg;
        ctl_next        = ctl_reg;
        key_next        = key_reg;
        add_next        = add_reg;
        nrep_next       = nrep_reg;
        run_mode_next   = run_mode_reg;
        pend_cmd_next   = pend_cmd_reg;
        pend_entry_next = pend_entry_reg;
        btick_next      = btick_reg;
        bcount_next     = bcount_reg;
        sp_next         = sp_reg;
        sc_next         = sc_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !report.ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        wr              = '0;
        cmd_in          = (item.command > CMD_BURST) ? CMD_NONE : item.command;
        bt_inc          = btick_reg + BC_W'(1);
        bc_inc          = bcount_reg + BC_W'(1);
        gen             = 1'b0;
        gen_ok          = 1'b0;
        stall           = 1'b0;
        more            = 1'b0;
        rep.endpoint    = 2'(fresh ? EP_W'(1) : ep_reg);
        rep.cluster     = rd_data.cluster;
        rep.attr        = rd_data.attr;
        rep.mfg         = rd_data.mfg;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_SHORT_PERIOD: sp_next = cfg.data;
                CFG_SHORT_COUNT:  sc_next = cfg.data;
                default:          sp_next = sp_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    idx_next = '0;
                    ep_next  = '0;
                    op_next  = item.mode;
                    unique case (item.mode)
                        MODE_CMD:
                        begin
                            pend_cmd_next = cmd_in;
                            if (cmd_in == CMD_REFRESH)
                            begin
                                pend_entry_next = item.entry_no;
                                btick_next      = '0;
                                bcount_next     = '0;
                            end
                        end
                        MODE_ADD:
                        begin
                            add_next.no        = item.entry_no;
                            add_next.cluster   = item.cluster_id;
                            add_next.attr      = item.attribute_id;
                            add_next.mfg       = item.is_mfg;
                            add_next.one_ep    = item.one_endpoint;
                            add_next.period    = item.period;
                            add_next.countdown = item.period;
                            state_next         = ST_WALK;
                        end
                        MODE_DEL:
                        begin
                            key_next   = item.entry_no;
                            state_next = ST_WALK;
                        end
                        MODE_TICK:
                        begin
                            // settle this tick's mode step, then walk the slots
                            ref_active_next = (pend_cmd_reg == CMD_REFRESH);
                            key_next        = pend_entry_reg;
                            ctl_next        = '0;
                            nrep_next       = '0;
                            pend_cmd_next   = CMD_NONE;
                            state_next      = ST_WALK;
                            case (run_mode_reg)
                                RUN_IDLE:
                                begin
                                    if (pend_cmd_reg == CMD_ENABLE)
                                    begin
                                        run_mode_next = RUN_REGULAR;
                                    end
                                    else if (pend_cmd_reg == CMD_BURST)
                                    begin
                                        run_mode_next = RUN_BURST;
                                        btick_next    = '0;
                                        bcount_next   = '0;
                                    end
                                end
                                RUN_REGULAR:
                                begin
                                    if (pend_cmd_reg == CMD_DISABLE)
                                    begin
                                        run_mode_next = RUN_IDLE;
                                    end
                                    else if (pend_cmd_reg == CMD_BURST)
                                    begin
                                        run_mode_next = RUN_BURST;
                                        btick_next    = '0;
                                        bcount_next   = '0;
                                    end
                                    else
                                    begin
                                        ctl_next.decrement = 1'b1;
                                    end
                                end
                                RUN_BURST:
                                begin
                                    if (pend_cmd_reg == CMD_DISABLE)
                                    begin
                                        run_mode_next = RUN_IDLE;
                                    end
                                    else if (bt_inc >= sp_reg)
                                    begin
                                        btick_next     = '0;
                                        ctl_next.burst = 1'b1;
                                        if (bc_inc >= sc_reg)
                                        begin
                                            bcount_next   = '0;
                                            run_mode_next = RUN_REGULAR;
                                        end
                                        else
                                        begin
                                            bcount_next = bc_inc;
                                        end
                                    end
                                    else
                                    begin
                                        btick_next = bt_inc;
                                    end
                                end
                                default:
                                begin
                                    run_mode_next = run_mode_reg;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                unique case (op_reg)
                    MODE_ADD:
                    begin
                        // take the first free slot; a full table drops the add
                        if (!rd_valid)
                        begin
                            wr.fill    = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (last_idx)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    MODE_DEL:
                    begin
                        wr.clear = key_match;
                        if (last_idx)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        gen    = fresh ? (rd_valid && fire) : 1'b1;
                        gen_ok = gen && (nrep_reg != CNT_W'(MAX_RESULTS));
                        stall  = gen_ok && hold_valid_reg && !out_free;
                        if (!stall)
                        begin
                            if (fresh && rd_valid)
                            begin
                                wr.cd_we = 1'b1;
                                wr.cd    = cd_next;
                            end
                            if (refresh_hit)
                            begin
                                ref_active_next = 1'b0;
                            end
                            if (gen_ok)
                            begin
                                // release the held report, hold the new one
                                if (hold_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next       = hold_reg;
                                    out_last_next  = 1'b0;
                                end
                                hold_valid_next = 1'b1;
                                hold_next       = rep;
                                nrep_next       = nrep_reg + CNT_W'(1);
                            end
                            if (fresh)
                            begin
                                more = rd_valid && fire && !rd_data.one_ep && (CHANNELS > 1);
                            end
                            else
                            begin
                                more = (ep_reg != EP_W'(CHANNELS));
                            end
                            if (more)
                            begin
                                ep_next = fresh ? EP_W'(2) : ep_reg + EP_W'(1);
                            end
                            else
                            begin
                                ep_next = '0;
                                if (last_idx)
                                begin
                                    state_next = ST_FLUSH;
                                end
                                else
                                begin
                                    idx_next = idx_reg + IDX_W'(1);
                                end
                            end
                        end
                    end
                endcase
            end

            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= MODE_TICK;
            idx_reg        <= '0;
            ep_reg         <= '0;
            ref_active_reg <= 1'b0;
            ctl_reg        <= '0;
            nrep_reg       <= '0;
            run_mode_reg   <= RUN_IDLE;
            pend_cmd_reg   <= CMD_NONE;
            pend_entry_reg <= '0;
            btick_reg      <= '0;
            bcount_reg     <= '0;
            sp_reg         <= 8'd10;
            sc_reg         <= 8'd3;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            ep_reg         <= ep_next;
            ref_active_reg <= ref_active_next;
            ctl_reg        <= ctl_next;
            nrep_reg       <= nrep_next;
            run_mode_reg   <= run_mode_next;
            pend_cmd_reg   <= pend_cmd_next;
            pend_entry_reg <= pend_entry_next;
            btick_reg      <= btick_next;
            bcount_reg     <= bcount_next;
            sp_reg         <= sp_next;
            sc_reg         <= sc_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        add_reg      <= add_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

[hdl/prs_checker.sv]
module prs_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_ready,
    input logic [1:0]               item_mode,
    input logic                     report_valid,
    input logic                     report_ready,
    input logic [1:0]               report_endpoint,
    input logic [prs_pkg::ID_W-1:0] report_cluster,
    input logic [prs_pkg::ID_W-1:0] report_attribute,
    input logic                     report_mfg,
    input logic                     report_last
);
    import prs_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge clk) !rst_n |-> !report_valid)
        else $error("report valid during reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid &&
        $stable({report_endpoint, report_cluster, report_attribute, report_mfg, report_last}))
        else $error("stalled report changed");

    // a tick starts the slot walk
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_mode == MODE_TICK |=> !item_ready)
        else $error("ready after tick accept");

    // a command beat completes in its own cycle
    a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_mode == MODE_CMD |=> item_ready)
        else $error("not ready after command");

endmodule

bind periodic_report_scheduler_unit prs_checker u_prs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_mode        (item.mode),
    .report_valid     (report.valid),
    .report_ready     (report.ready),
    .report_endpoint  (report.endpoint),
    .report_cluster   (report.report_cluster),
    .report_attribute (report.report_attribute),
    .report_mfg       (report.report_mfg),
    .report_last      (report.last)
);
